// ===== rtl/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes of the sorted record table
// Word layouts of the request and response channels, the stored record and
// the per-cell control bundle.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int KEY_W   = 27;
   localparam int AGE_W   = 8;
   localparam int NAMEL_W = 64;
   localparam int NAMEH_W = 48;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_FOUND     = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_EMPTY     = 3'd4;

   typedef struct packed {
      logic               cmd;
      logic [KEY_W-1:0]   key;
      logic [AGE_W-1:0]   age;
      logic [NAMEL_W-1:0] name_low;
      logic [NAMEH_W-1:0] name_high;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [KEY_W-1:0]   found_key;
      logic [AGE_W-1:0]   found_age;
      logic [NAMEL_W-1:0] found_name_low;
      logic [NAMEH_W-1:0] found_name_high;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [AGE_W-1:0]   age;
      logic [NAMEL_W-1:0] name_low;
      logic [NAMEH_W-1:0] name_high;
   } record_type;

   typedef struct packed {
      logic insert;
      logic rotate;
   } cell_ctrl_type;

endpackage

// ===== rtl/sorted_record_table.sv =====
// ----------------------------------------------------------------------------
// sorted_record_table: record table kept in ascending key order
// A row of CAPACITY cells holds the records; inserts shift all cells at once,
// lookups rotate the row once through cell 0.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one command word (insert or look up by key),
// the rsp_ channel returns exactly one status word for each command.
// An insert is decided by all cells at once and its response appears in the cycle
// after acceptance. A lookup rotates the records through cell 0, one cell per
// cycle, and no new command is taken until its result has been loaded into the
// output register. Sustained rate is one insert per cycle while rsp_ready stays
// high.
// The response sits in an output register; a lookup is accepted while an
// earlier response still waits, and an insert is accepted when that register
// is empty or being read in the same cycle. While rsp_ready is low, a finished
// lookup holds its result and no new command is taken.
// Reset empties the table and drops any pending response; stored records need
// no clearing since only occupied cells are ever compared or returned.
// ----------------------------------------------------------------------------
module sorted_record_table #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srt_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                hit_ff, hit_in;
   srt_pkg::record_type hit_rec_ff, hit_rec_in;
   logic [srt_pkg::KEY_W-1:0] key_ff, key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   srt_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   srt_pkg::record_type    new_rec;
   srt_pkg::record_type    recs [CAPACITY];
   logic [CAPACITY-1:0]    lt;
   logic [CAPACITY-1:0]    occupied;
   srt_pkg::cell_ctrl_type ctrl;

   logic accept, slot_free, full, do_insert, scan_done, rsp_load;

   assign new_rec.key       = req_data.key;
   assign new_rec.age       = req_data.age;
   assign new_rec.name_low  = req_data.name_low;
   assign new_rec.name_high = req_data.name_high;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = (fill_ff == CW'(CAPACITY));
   assign req_ready = (state_ff == ST_IDLE) &&
                      (slot_free || (req_data.cmd == srt_pkg::CMD_LOOKUP));
   assign accept    = req_valid && req_ready;
   assign do_insert = accept && (req_data.cmd == srt_pkg::CMD_INSERT) && !full;
   assign scan_done = (state_ff == ST_SCAN) && (scan_ff == CW'(CAPACITY));
   assign rsp_load  = (accept && (req_data.cmd == srt_pkg::CMD_INSERT)) ||
                      (scan_done && slot_free);

   assign ctrl.insert = do_insert;
   assign ctrl.rotate = (state_ff == ST_SCAN) && (scan_ff < CW'(CAPACITY));

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = (CW'(i) < fill_ff);
      srt_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .take_new  ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
         .occupied  (occupied[i]),
         .new_rec   (new_rec),
         .left_rec  ((i == 0) ? new_rec : recs[(i == 0) ? 0 : i - 1]),
         .right_rec (recs[(i + 1) % CAPACITY]),
         .rec       (recs[i]),
         .lt        (lt[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      hit_rec_in   = hit_rec_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.cmd == srt_pkg::CMD_LOOKUP)) begin
               state_in = ST_SCAN;
               scan_in  = '0;
               hit_in   = 1'b0;
               key_in   = req_data.key;
            end
         end
         ST_SCAN: begin
            if (ctrl.rotate) begin
               // Cell 0 holds record number scan_ff during this step.
               if (!hit_ff && (scan_ff < fill_ff) && (recs[0].key == key_ff)) begin
                  hit_in     = 1'b1;
                  hit_rec_in = recs[0];
               end
               scan_in = scan_ff + CW'(1);
            end else if (scan_done && slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (do_insert) begin
         fill_in = fill_ff + CW'(1);
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (state_ff == ST_IDLE) begin
            rsp_data_in.status      = full ? srt_pkg::STATUS_FULL :
                                             srt_pkg::STATUS_INSERTED;
            rsp_data_in.entry_count = srt_pkg::COUNT_W'(fill_in);
         end else begin
            rsp_data_in.entry_count = srt_pkg::COUNT_W'(fill_ff);
            if (fill_ff == '0) begin
               rsp_data_in.status = srt_pkg::STATUS_EMPTY;
            end else if (hit_ff) begin
               rsp_data_in.status          = srt_pkg::STATUS_FOUND;
               rsp_data_in.found_key       = hit_rec_ff.key;
               rsp_data_in.found_age       = hit_rec_ff.age;
               rsp_data_in.found_name_low  = hit_rec_ff.name_low;
               rsp_data_in.found_name_high = hit_rec_ff.name_high;
            end else begin
               rsp_data_in.status = srt_pkg::STATUS_NOT_FOUND;
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_rec_ff  <= hit_rec_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/srt_cell.sv =====
// ----------------------------------------------------------------------------
// srt_cell: one record slot of the table
// Compares its key with the incoming key, and either keeps its record, takes
// the new record, takes its left neighbor's record, or rotates from the right.
// ----------------------------------------------------------------------------
module srt_cell (
   input  logic                   clock,
   input  srt_pkg::cell_ctrl_type ctrl,
   input  logic                   take_new,
   input  logic                   occupied,
   input  srt_pkg::record_type    new_rec,
   input  srt_pkg::record_type    left_rec,
   input  srt_pkg::record_type    right_rec,
   output srt_pkg::record_type    rec,
   output logic                   lt
);

   srt_pkg::record_type rec_ff;
   srt_pkg::record_type rec_in;

   assign lt  = occupied && (rec_ff.key < new_rec.key);
   assign rec = rec_ff;

   always_comb begin
      priority if (ctrl.rotate) begin
         rec_in = right_rec;
      end else if (ctrl.insert && !lt) begin
         // The first cell that is not smaller takes the new word; the rest
         // move one place toward the tail.
         rec_in = take_new ? new_rec : left_rec;
      end else begin
         rec_in = rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// ===== rtl/srt_checker.sv =====
// ----------------------------------------------------------------------------
// srt_checker: port-level checks of the sorted record table
// Watches the response channel for handshake and status consistency.
// ----------------------------------------------------------------------------
module srt_checker #(
   parameter int CAPACITY = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input srt_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed or dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == srt_pkg::STATUS_FULL) |->
         rsp_data.entry_count == srt_pkg::COUNT_W'(CAPACITY))
      else $error("table full reported with a count below capacity");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == srt_pkg::STATUS_EMPTY) |->
         (rsp_data.entry_count == '0) && (rsp_data.found_key == '0))
      else $error("empty table reported with records or a match");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.status == srt_pkg::STATUS_INSERTED) ||
         (rsp_data.status == srt_pkg::STATUS_FULL) ||
         (rsp_data.status == srt_pkg::STATUS_FOUND) ||
         (rsp_data.status == srt_pkg::STATUS_NOT_FOUND) ||
         (rsp_data.status == srt_pkg::STATUS_EMPTY))
      else $error("undefined status code on the response channel");

endmodule

bind sorted_record_table srt_checker #(.CAPACITY(CAPACITY)) u_srt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
